### rtl/kto_pkg.sv
// Shared types and constants of the keyed timeout table.
package kto_pkg;

    // Table geometry.
    localparam int TIMER_SLOTS = 16;
    localparam int MAX_OUT     = 16;
    localparam int CW          = $clog2(TIMER_SLOTS + 1);
    localparam int OW          = $clog2(MAX_OUT + 1);
    localparam logic [15:0] TPS_RESET = 16'd100;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EXPIRED   = 3'd5
    } t_status;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_DROP,
        CELL_GROW
    } t_cell_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WHEN,
        S_SCAN,
        S_FINISH
    } t_state;

    // One stored timer.
    typedef struct packed {
        logic [31:0] cookie;
        logic [47:0] expiry;
        logic [7:0]  tag;
    } t_entry;

    // Control bundle from the sequencer to the cells.
    typedef struct packed {
        t_cell_op    op;
        logic [CW-1:0] cnt;
        logic [31:0] key;
        t_entry      fb;
    } t_cell_ctl;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] cookie;
        logic [7:0]  tag;
        logic        last;
    } t_result;

endpackage

### rtl/kto_if.sv
// Handshake channel interfaces of the keyed timeout table.
interface kto_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] cookie;
    logic [15:0] delay_seconds;
    logic [7:0]  handler_tag;
    modport source (output valid, req_type, cookie, delay_seconds, handler_tag, input ready);
    modport sink   (input valid, req_type, cookie, delay_seconds, handler_tag, output ready);
endinterface

interface kto_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_cookie;
    logic [7:0]  result_tag;
    logic        last_of_run;
    modport source (output valid, status, result_cookie, result_tag, last_of_run, input ready);
    modport sink   (input valid, status, result_cookie, result_tag, last_of_run, output ready);
endinterface

interface kto_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] ticks_per_second;
    modport source (output valid, ticks_per_second, input ready);
    modport sink   (input valid, ticks_per_second, output ready);
endinterface

### rtl/kto_cell.sv
// One list position of the timer chain: holds an entry and shifts with its neighbors.
module kto_cell
    import kto_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_index,
    input  t_cell_ctl     i_ctl,
    input  logic          i_right_valid,
    input  t_entry        i_right,
    output logic          o_valid,
    output t_entry        o_entry,
    output logic          o_match
);

    logic          r_valid;
    logic          n_valid;
    t_entry        r_ent;
    t_entry        n_ent;
    logic [CW-1:0] w_next_idx;

    assign w_next_idx = i_index + CW'(1);

    // Queue move: take the right neighbor, take the pushed entry at the tail, clear the tail, or hold.
    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        case (i_ctl.op)
            CELL_ROT: begin
                if (w_next_idx < i_ctl.cnt) begin
                    n_valid = i_right_valid;
                    n_ent   = i_right;
                end else if (w_next_idx == i_ctl.cnt) begin
                    n_valid = 1'b1;
                    n_ent   = i_ctl.fb;
                end
            end
            CELL_DROP: begin
                if (w_next_idx < i_ctl.cnt) begin
                    n_valid = i_right_valid;
                    n_ent   = i_right;
                end else if (w_next_idx == i_ctl.cnt) begin
                    n_valid = 1'b0;
                end
            end
            CELL_GROW: begin
                if (i_index == i_ctl.cnt) begin
                    n_valid = 1'b1;
                    n_ent   = i_ctl.fb;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // Valid flag is control state; the entry itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_valid = r_valid;
    assign o_entry = r_ent;
    assign o_match = r_valid && (r_ent.cookie == i_ctl.key);

endmodule

### rtl/keyed_timeout_table.sv
// Top level of the keyed timeout table: sequencer, time counter and the cell chain.
//
//  Channel   Direction  Fields
//  req       in         req_type, cookie, delay_seconds, handler_tag
//  res       out        status, result_cookie, result_tag, last_of_run
//  cfg       in         ticks_per_second
//
// An item passes the states PREP, WHEN, SCAN and FINISH before the next acceptance; SCAN visits
// each active timer and also the insert; a request of the unused type goes from PREP back to IDLE.
// The entries rotate once through the cell chain, one position per cycle except while a tick stalls.
// A tick that expires several timers stalls on each result while the output is full.
// Reset empties the table, zeroes time and sets ticks_per_second to 100.
// The next item is taken once the last result of the current one is registered.
module keyed_timeout_table
    import kto_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    kto_req_if.sink   req,
    kto_res_if.source res,
    kto_cfg_if.sink   cfg
);

    t_state        r_state;
    t_state        n_state;
    t_req          r_op;
    logic [31:0]   r_cookie;
    logic [15:0]   r_dly;
    logic [7:0]    r_tag;
    logic [15:0]   r_tps;
    logic [31:0]   r_prod;
    logic [47:0]   r_when;
    logic [47:0]   r_now;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_left;
    logic          r_found;
    logic          r_full;
    logic          r_ins_done;
    logic [OW-1:0] r_nout;
    logic          r_pend_valid;
    logic [31:0]   r_pend_cookie;
    logic [7:0]    r_pend_tag;
    logic          r_out_valid;
    t_result       r_out;

    t_cell_ctl              w_ctl;
    t_entry                 w_ent [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] w_val;
    logic [TIMER_SLOTS-1:0] w_match;
    logic                   w_can_emit;
    logic                   w_need_ins;
    logic                   w_pop;
    logic                   w_grow;
    logic                   w_capture;
    logic                   w_scan_end;
    logic                   w_fin_done;
    logic                   w_out_load;
    t_result                w_out_next;
    logic                   w_accept;

    assign w_accept   = req.valid && req.ready;
    assign w_can_emit = !r_out_valid || res.ready;
    assign w_need_ins = (r_op == REQ_SET) && !r_found && !r_full;

    // Cell chain; the last cell has no right neighbor.
    for (genvar gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
        if (gi == TIMER_SLOTS - 1) begin : g_tail
            kto_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_index       (CW'(gi)),
                .i_ctl         (w_ctl),
                .i_right_valid (1'b0),
                .i_right       (w_ent[gi]),
                .o_valid       (w_val[gi]),
                .o_entry       (w_ent[gi]),
                .o_match       (w_match[gi])
            );
        end else begin : g_body
            kto_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_index       (CW'(gi)),
                .i_ctl         (w_ctl),
                .i_right_valid (w_val[gi+1]),
                .i_right       (w_ent[gi+1]),
                .o_valid       (w_val[gi]),
                .o_entry       (w_ent[gi]),
                .o_match       (w_match[gi])
            );
        end
    end

    // Per-cycle step of the scan and the finish: what the head of the chain does and which result is loaded.
    always_comb begin
        w_ctl.op   = CELL_HOLD;
        w_ctl.cnt  = r_cnt;
        w_ctl.key  = r_cookie;
        w_ctl.fb   = w_ent[0];
        w_pop      = 1'b0;
        w_grow     = 1'b0;
        w_capture  = 1'b0;
        w_scan_end = 1'b0;
        w_fin_done = 1'b0;
        w_out_load = 1'b0;
        w_out_next = '{status: ST_EXPIRED, cookie: r_pend_cookie, tag: r_pend_tag, last: 1'b0};
        if (r_state == S_SCAN) begin
            if (r_left == '0) begin
                if (w_need_ins && !r_ins_done) begin
                    w_ctl.op = CELL_GROW;
                    w_ctl.fb = '{cookie: r_cookie, expiry: r_when, tag: r_tag};
                    w_grow   = 1'b1;
                end else begin
                    w_scan_end = 1'b1;
                end
            end else begin
                case (r_op)
                    REQ_SET: begin
                        if (w_need_ins && !r_ins_done && (w_ent[0].expiry > r_when)) begin
                            w_ctl.op = CELL_GROW;
                            w_ctl.fb = '{cookie: r_cookie, expiry: r_when, tag: r_tag};
                            w_grow   = 1'b1;
                        end else begin
                            w_ctl.op = CELL_ROT;
                            w_pop    = 1'b1;
                            if (r_found && w_match[0]) begin
                                w_ctl.fb = '{cookie: w_ent[0].cookie, expiry: r_when, tag: r_tag};
                            end
                        end
                    end
                    REQ_CANCEL: begin
                        w_ctl.op = w_match[0] ? CELL_DROP : CELL_ROT;
                        w_pop    = 1'b1;
                    end
                    REQ_TICK: begin
                        if ((w_ent[0].expiry <= r_now) && (r_nout < OW'(MAX_OUT))) begin
                            if (!r_pend_valid || w_can_emit) begin
                                w_ctl.op   = CELL_DROP;
                                w_pop      = 1'b1;
                                w_capture  = 1'b1;
                                w_out_load = r_pend_valid;
                            end
                        end else begin
                            w_ctl.op = CELL_ROT;
                            w_pop    = 1'b1;
                        end
                    end
                    default: begin
                        w_ctl.op = CELL_ROT;
                        w_pop    = 1'b1;
                    end
                endcase
            end
        end else if (r_state == S_FINISH) begin
            if (r_op == REQ_TICK) begin
                w_out_next.last = 1'b1;
                if (!r_pend_valid) begin
                    w_fin_done = 1'b1;
                end else if (w_can_emit) begin
                    w_out_load = 1'b1;
                    w_fin_done = 1'b1;
                end
            end else begin
                w_out_next.cookie = r_cookie;
                w_out_next.tag    = '0;
                w_out_next.last   = 1'b1;
                if (r_op == REQ_SET) begin
                    w_out_next.status = r_found ? ST_UPDATED : (r_full ? ST_FULL : ST_INSERTED);
                end else begin
                    w_out_next.status = r_found ? ST_CANCELLED : ST_NOT_FOUND;
                end
                if (w_can_emit) begin
                    w_out_load = 1'b1;
                    w_fin_done = 1'b1;
                end
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_PREP;
            S_PREP:   n_state = (r_op == REQ_NONE) ? S_IDLE : S_WHEN;
            S_WHEN:   n_state = S_SCAN;
            S_SCAN:   if (w_scan_end) n_state = S_FINISH;
            S_FINISH: if (w_fin_done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        req.ready               = (r_state == S_IDLE);
        cfg.ready               = 1'b1;
        res.valid               = r_out_valid;
        res.status              = r_out.status;
        res.result_cookie       = r_out.cookie;
        res.result_tag          = r_out.tag;
        res.last_of_run         = r_out.last;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tps        <= TPS_RESET;
            r_now        <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg.valid && cfg.ready) begin
                r_tps <= cfg.ticks_per_second;
            end
            if (r_state == S_WHEN && r_op == REQ_TICK) begin
                r_now <= r_now + 48'd1;
            end
            if (w_ctl.op == CELL_DROP) begin
                r_cnt <= r_cnt - CW'(1);
            end else if (w_grow) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (w_capture) begin
                r_pend_valid <= 1'b1;
            end else if (r_state == S_FINISH && w_fin_done) begin
                r_pend_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and scan working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_req'(req.req_type);
            r_cookie <= req.cookie;
            r_dly    <= req.delay_seconds;
            r_tag    <= req.handler_tag;
        end
        if (r_state == S_PREP) begin
            r_prod     <= 32'(r_tps) * 32'(r_dly);
            r_found    <= |w_match;
            r_full     <= (r_cnt == CW'(TIMER_SLOTS));
            r_left     <= r_cnt;
            r_ins_done <= 1'b0;
            r_nout     <= '0;
        end
        if (r_state == S_WHEN) begin
            r_when <= r_now + 48'(r_prod);
        end
        if (w_pop) begin
            r_left <= r_left - CW'(1);
        end
        if (w_grow) begin
            r_ins_done <= 1'b1;
        end
        if (w_capture) begin
            r_pend_cookie <= w_ent[0].cookie;
            r_pend_tag    <= w_ent[0].tag;
            r_nout        <= r_nout + OW'(1);
        end
        if (w_out_load) begin
            r_out <= w_out_next;
        end
    end

    // The active count never passes the table size.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TIMER_SLOTS))
        else $error("active count beyond table size");

    // Between items the valid cells are exactly as many as the active count.
    a_cnt_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(w_val) == int'(r_cnt)))
        else $error("valid cells disagree with active count");

    // Only a tick holds a pending expiry.
    a_pend_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_op == REQ_TICK))
        else $error("pending expiry outside a tick");

    // A result never overwrites one that is still waiting.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || res.ready))
        else $error("result register overrun");

endmodule

### test/kto_tb_pkg.sv
// Scoreboard class that predicts and checks the results of the keyed timeout table.
`timescale 1ns / 1ps
package kto_tb_pkg;
    import kto_pkg::*;

    class timeout_scoreboard;
        // Predicted table contents, kept as a list in expiry order.
        logic [47:0] clock_now;
        logic [15:0] rate;
        logic [31:0] list_cookie[$];
        logic [47:0] list_expiry[$];
        logic [7:0]  list_tag[$];
        t_result     pending[$];
        int          mismatches;
        int          checked;

        function new();
            clock_now = '0;
            rate = TPS_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_rate(logic [15:0] value);
            rate = value;
        endfunction

        function int find_cookie(logic [31:0] ck);
            int idx;
            idx = -1;
            foreach (list_cookie[p]) begin
                if (idx < 0 && list_cookie[p] == ck) begin
                    idx = p;
                end
            end
            return idx;
        endfunction

        function void push_result(t_status st, logic [31:0] ck, logic [7:0] tg, logic lst);
            t_result r;
            r.status = st;
            r.cookie = ck;
            r.tag = tg;
            r.last = lst;
            pending.push_back(r);
        endfunction

        // Notes one accepted request and queues the results it causes.
        function void note_request(t_req rq, logic [31:0] ck, logic [15:0] dly,
                                   logic [7:0] tg);
            logic [47:0] when;
            int pos;
            int n;
            int p;
            t_result r;
            when = clock_now + 48'(rate) * 48'(dly);
            case (rq)
                REQ_SET: begin
                    pos = find_cookie(ck);
                    if (pos >= 0) begin
                        list_expiry[pos] = when;
                        list_tag[pos] = tg;
                        push_result(ST_UPDATED, ck, 8'd0, 1'b1);
                    end else if (list_cookie.size() >= TIMER_SLOTS) begin
                        push_result(ST_FULL, ck, 8'd0, 1'b1);
                    end else begin
                        p = 0;
                        while (p < list_cookie.size() && list_expiry[p] <= when) begin
                            p++;
                        end
                        list_cookie.insert(p, ck);
                        list_expiry.insert(p, when);
                        list_tag.insert(p, tg);
                        push_result(ST_INSERTED, ck, 8'd0, 1'b1);
                    end
                end
                REQ_CANCEL: begin
                    pos = find_cookie(ck);
                    if (pos >= 0) begin
                        list_cookie.delete(pos);
                        list_expiry.delete(pos);
                        list_tag.delete(pos);
                        push_result(ST_CANCELLED, ck, 8'd0, 1'b1);
                    end else begin
                        push_result(ST_NOT_FOUND, ck, 8'd0, 1'b1);
                    end
                end
                REQ_TICK: begin
                    clock_now = clock_now + 48'd1;
                    n = 0;
                    p = 0;
                    while (p < list_cookie.size() && n < MAX_OUT) begin
                        if (list_expiry[p] <= clock_now) begin
                            push_result(ST_EXPIRED, list_cookie[p], list_tag[p], 1'b0);
                            list_cookie.delete(p);
                            list_expiry.delete(p);
                            list_tag.delete(p);
                            n++;
                        end else begin
                            p++;
                        end
                    end
                    if (n > 0) begin
                        r = pending.pop_back();
                        r.last = 1'b1;
                        pending.push_back(r);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: status %0d cookie %h tag %h last %b",
                             got.status, got.cookie, got.tag, got.last);
                end
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected status %0d cookie %h tag %h last %b",
                             want.status, want.cookie, want.tag, want.last);
                    $display("          actual   status %0d cookie %h tag %h last %b",
                             got.status, got.cookie, got.tag, got.last);
                end
            end
        endfunction
    endclass
endpackage

### test/keyed_timeout_table_tb.sv
// Testbench top of the keyed timeout table: directed and random requests, checked by a scoreboard.
`timescale 1ns / 1ps
module keyed_timeout_table_tb;
    import kto_pkg::*;
    import kto_tb_pkg::*;

    localparam longint CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    longint cycles;
    bit     idle_on;
    bit     hold_off;
    int     done_items;

    kto_req_if req ();
    kto_res_if res ();
    kto_cfg_if cfg ();

    timeout_scoreboard sb;

    keyed_timeout_table DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .req    (req.sink),
        .res    (res.source),
        .cfg    (cfg.sink)
    );

    // Clock, 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Cycle counter with a hard limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result sink: random stall bursts, plus one long hold-off on request.
    initial begin
        int gap;
        t_result got;
        res.ready = 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_off) begin
                res.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                res.ready <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge i_clk);
            end else begin
                res.ready <= 1'b1;
                @(posedge i_clk);
                if (res.valid && res.ready) begin
                    got.status = t_status'(res.status);
                    got.cookie = res.result_cookie;
                    got.tag = res.result_tag;
                    got.last = res.last_of_run;
                    sb.check_result(got);
                end
            end
        end
    end

    // Sends one request and notes it once accepted.
    task automatic send_request(t_req rq, logic [31:0] ck, logic [15:0] dly, logic [7:0] tg);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.req_type <= rq;
        req.cookie <= ck;
        req.delay_seconds <= dly;
        req.handler_tag <= tg;
        do begin
            @(posedge i_clk);
        end while (!req.ready);
        sb.note_request(rq, ck, dly, tg);
        done_items++;
    endtask

    // Waits for all results, lets the block settle, then writes the rate register.
    task automatic write_rate(logic [15:0] value);
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.ticks_per_second <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.set_rate(value);
    endtask

    // One random request drawn from a small cookie pool so hits are common.
    task automatic random_request(int pool);
        int pick;
        logic [31:0] ck;
        logic [15:0] dly;
        pick = $urandom_range(0, 99);
        ck = (pool > 0 && $urandom_range(0, 9) != 0) ? 32'($urandom_range(0, pool))
                                                    : 32'($urandom);
        dly = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        if (pick < 40) begin
            send_request(REQ_SET, ck, dly, 8'($urandom));
        end else if (pick < 52) begin
            send_request(REQ_CANCEL, ck, 16'($urandom), 8'($urandom));
        end else if (pick < 97) begin
            send_request(REQ_TICK, 32'($urandom), 16'($urandom), 8'($urandom));
        end else begin
            send_request(REQ_NONE, 32'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    // Main stimulus.
    initial begin
        int k;
        sb = new();
        cycles = 0;
        idle_on = 1'b0;
        hold_off = 1'b0;
        done_items = 0;
        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_NONE;
        req.cookie = '0;
        req.delay_seconds = '0;
        req.handler_tag = '0;
        cfg.valid = 1'b0;
        cfg.ticks_per_second = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero rate, fill the table, overflow, update, cancel hit and miss.
        write_rate(16'd0);
        send_request(REQ_SET, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_request(REQ_TICK, 32'd0, 16'd0, 8'd0);
        for (k = 0; k < TIMER_SLOTS; k++) begin
            send_request(REQ_SET, 32'(k), 16'(k), 8'(k * 7));
        end
        send_request(REQ_SET, 32'hDEAD_BEEF, 16'd1, 8'h55);
        send_request(REQ_SET, 32'd3, 16'd9, 8'hAA);
        send_request(REQ_CANCEL, 32'd5, 16'd0, 8'd0);
        send_request(REQ_CANCEL, 32'h1234_5678, 16'd0, 8'd0);
        send_request(REQ_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_request(REQ_TICK, 32'd0, 16'd0, 8'd0);

        // Directed: a large rate; the whole table is set with zero delay, so it is all due on one tick later.
        write_rate(16'hFFFF);
        for (k = 0; k < TIMER_SLOTS; k++) begin
            send_request(REQ_SET, 32'(k + 100), 16'd0, 8'(k));
        end
        send_request(REQ_SET, 32'd200, 16'hFFFF, 8'h01);
        send_request(REQ_TICK, 32'd0, 16'd0, 8'd0);

        // Random phases, with idling in the first two and one long output hold-off in the first.
        write_rate(16'd1);
        idle_on = 1'b1;
        hold_off = 1'b1;
        for (k = 0; k < 130; k++) begin
            random_request(24);
        end
        write_rate(16'd3);
        for (k = 0; k < 130; k++) begin
            random_request(40);
        end
        write_rate(16'd1);
        idle_on = 1'b0;
        for (k = 0; k < 80; k++) begin
            random_request(20);
        end
        req.valid <= 1'b0;

        // Drain and settle.
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### sim.f
rtl/kto_pkg.sv
rtl/kto_if.sv
rtl/kto_cell.sv
rtl/keyed_timeout_table.sv
test/kto_tb_pkg.sv
test/keyed_timeout_table_tb.sv
